// ===== rtl/bpss_pkg.sv =====
// ----------------------------------------------------------------------------
// bpss_pkg
// Shared constants, codes and controller/datapath interface types for the
// best patch SAD search unit.
// ----------------------------------------------------------------------------
package bpss_pkg;

    localparam int LIBRARY_DEPTH = 1024;
    localparam int TARGET_DEPTH  = 4096;
    localparam int PATCH_BYTES   = 192;

    localparam int LIB_WORDS = LIBRARY_DEPTH * 2 * PATCH_BYTES;
    localparam int TGT_WORDS = TARGET_DEPTH * PATCH_BYTES;
    localparam int LIB_AW    = $clog2(LIB_WORDS);
    localparam int TGT_AW    = $clog2(TGT_WORDS);
    localparam int SHAPE_AW  = $clog2(LIBRARY_DEPTH);

    localparam int REQ_W    = 2;
    localparam int TILE_W   = 10;
    localparam int TGT_W    = 12;
    localparam int POS_W    = 9;
    localparam int PIX_W    = 8;
    localparam int SHAPE_W  = 2;
    localparam int LCOUNT_W = 11;
    localparam int TCOUNT_W = 13;
    localparam int SCORE_W  = 20;
    localparam int CFG_AW   = 4;
    localparam int CFG_DW   = 32;

    localparam int BYTE_W = $clog2(PATCH_BYTES);
    localparam int ACC_W  = $clog2(2 * PATCH_BYTES * 255 + 1);
    localparam int SUM_W  = 24;
    localparam int NB_W   = TCOUNT_W + 1;

    localparam logic [REQ_W-1:0] REQ_LIB_LOAD = 2'd0;
    localparam logic [REQ_W-1:0] REQ_TGT_LOAD = 2'd1;
    localparam logic [REQ_W-1:0] REQ_SEARCH   = 2'd2;

    localparam logic [SHAPE_W-1:0] SHAPE_SQUARE    = 2'd0;
    localparam logic [SHAPE_W-1:0] SHAPE_LANDSCAPE = 2'd1;
    localparam logic [SHAPE_W-1:0] SHAPE_PORTRAIT  = 2'd2;

    localparam logic [1:0] REG_LIBRARY_COUNT = 2'd0;
    localparam logic [1:0] REG_TARGET_COUNT  = 2'd1;
    localparam logic [1:0] REG_COLUMN_HEIGHT = 2'd2;

    localparam logic [SCORE_W-1:0] SCORE_LIMIT       = 20'd1000000;
    localparam logic [SUM_W-1:0]   LANDSCAPE_PENALTY = 24'd100000;
    localparam logic [SUM_W-1:0]   PORTRAIT_PENALTY  = 24'd10000000;

    typedef struct packed {
        logic              lib_wr;
        logic              tgt_wr;
        logic              search_init;
        logic              shape_rd;
        logic              tile_setup;
        logic              pix_rd;
        logic              second_half;
        logic [TILE_W-1:0] tile;
        logic [BYTE_W-1:0] byte_idx;
        logic              score_en;
    } dp_cmd_t;

    typedef struct packed {
        logic [SHAPE_W-1:0] shape;
        logic               nb_present;
        logic               tgt_in_range;
    } dp_status_t;

endpackage

// ===== rtl/bpss_ctrl.sv =====
// ----------------------------------------------------------------------------
// bpss_ctrl
// Sequencer for loads and searches: walks the library tiles, the cells of
// each tile and the bytes of each cell, and issues datapath commands.
// ----------------------------------------------------------------------------
module bpss_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [bpss_pkg::REQ_W-1:0]    req_type,
    input  logic [bpss_pkg::LCOUNT_W-1:0] library_count,
    input  bpss_pkg::dp_status_t          status,
    output bpss_pkg::dp_cmd_t             cmd,
    output logic                          busy,
    output logic                          done
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SHAPE  = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_CELL0  = 3'd3;
    localparam logic [2:0] S_CELL1  = 3'd4;
    localparam logic [2:0] S_DRAIN  = 3'd5;
    localparam logic [2:0] S_SCORE  = 3'd6;
    localparam logic [2:0] S_DONE   = 3'd7;

    logic [2:0]                          state_reg, state_next;
    logic [bpss_pkg::LCOUNT_W-1:0]       tile_reg, tile_next;
    logic [bpss_pkg::LCOUNT_W-1:0]       count_reg, count_next;
    logic [bpss_pkg::BYTE_W-1:0]         byte_reg, byte_next;
    logic                                two_reg, two_next;
    logic [bpss_pkg::LCOUNT_W-1:0]       scan_limit;
    logic                                byte_last;

    assign scan_limit = (library_count < bpss_pkg::LCOUNT_W'(bpss_pkg::LIBRARY_DEPTH))
                        ? library_count : bpss_pkg::LCOUNT_W'(bpss_pkg::LIBRARY_DEPTH);
    assign byte_last  = (byte_reg == bpss_pkg::BYTE_W'(bpss_pkg::PATCH_BYTES - 1));

    always_comb
    begin
        state_next = state_reg;
        tile_next  = tile_reg;
        count_next = count_reg;
        byte_next  = byte_reg;
        two_next   = two_reg;
        cmd        = '0;
        cmd.tile     = tile_reg[bpss_pkg::TILE_W-1:0];
        cmd.byte_idx = byte_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.lib_wr = (req_type == bpss_pkg::REQ_LIB_LOAD);
                    cmd.tgt_wr = (req_type == bpss_pkg::REQ_TGT_LOAD);
                    if (req_type == bpss_pkg::REQ_SEARCH)
                    begin
                        cmd.search_init = 1'b1;
                        tile_next  = '0;
                        count_next = status.tgt_in_range ? scan_limit : '0;
                        state_next = S_SHAPE;
                    end
                end
            end
            S_SHAPE:
            begin
                if (tile_reg < count_reg)
                begin
                    cmd.shape_rd = 1'b1;
                    state_next   = S_DECIDE;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DECIDE:
            begin
                if (status.shape == bpss_pkg::SHAPE_SQUARE
                    || status.shape == bpss_pkg::SHAPE_LANDSCAPE
                    || status.shape == bpss_pkg::SHAPE_PORTRAIT)
                begin
                    cmd.tile_setup = 1'b1;
                    two_next   = (status.shape != bpss_pkg::SHAPE_SQUARE) && status.nb_present;
                    byte_next  = '0;
                    state_next = S_CELL0;
                end
                else
                begin
                    tile_next  = tile_reg + 1'b1;
                    state_next = S_SHAPE;
                end
            end
            S_CELL0:
            begin
                cmd.pix_rd      = 1'b1;
                cmd.second_half = 1'b0;
                if (byte_last)
                begin
                    byte_next  = '0;
                    state_next = two_reg ? S_CELL1 : S_DRAIN;
                end
                else
                begin
                    byte_next = byte_reg + 1'b1;
                end
            end
            S_CELL1:
            begin
                cmd.pix_rd      = 1'b1;
                cmd.second_half = 1'b1;
                if (byte_last)
                begin
                    byte_next  = '0;
                    state_next = S_DRAIN;
                end
                else
                begin
                    byte_next = byte_reg + 1'b1;
                end
            end
            S_DRAIN:
            begin
                state_next = S_SCORE;
            end
            S_SCORE:
            begin
                cmd.score_en = 1'b1;
                tile_next    = tile_reg + 1'b1;
                state_next   = S_SHAPE;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            tile_reg  <= '0;
            count_reg <= '0;
            byte_reg  <= '0;
            two_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            tile_reg  <= tile_next;
            count_reg <= count_next;
            byte_reg  <= byte_next;
            two_reg   <= two_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_DONE);

endmodule

// ===== rtl/bpss_datapath.sv =====
// ----------------------------------------------------------------------------
// bpss_datapath
// Patch memories, neighbour check, SAD accumulator and best-score tracking.
// ----------------------------------------------------------------------------
module bpss_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  bpss_pkg::dp_cmd_t             cmd,
    output bpss_pkg::dp_status_t          status,
    input  logic [bpss_pkg::TILE_W-1:0]   library_index,
    input  logic [bpss_pkg::TGT_W-1:0]    target_index,
    input  logic [bpss_pkg::POS_W-1:0]    byte_position,
    input  logic [bpss_pkg::PIX_W-1:0]    pixel_value,
    input  logic [bpss_pkg::SHAPE_W-1:0]  tile_shape,
    input  logic [bpss_pkg::TCOUNT_W-1:0] target_count,
    input  logic [bpss_pkg::TCOUNT_W-1:0] column_height,
    output logic [bpss_pkg::TILE_W-1:0]   best_entry,
    output logic [bpss_pkg::SCORE_W-1:0]  min_score,
    output logic                          match_found
);

    logic [bpss_pkg::PIX_W-1:0]   lib_mem   [bpss_pkg::LIB_WORDS];
    logic [bpss_pkg::PIX_W-1:0]   tgt_mem   [bpss_pkg::TGT_WORDS];
    logic [bpss_pkg::SHAPE_W-1:0] shape_mem [bpss_pkg::LIBRARY_DEPTH];

    logic [bpss_pkg::PIX_W-1:0]   lib_q_reg;
    logic [bpss_pkg::PIX_W-1:0]   tgt_q_reg;
    logic [bpss_pkg::SHAPE_W-1:0] shape_q_reg;
    logic                         valid_reg;
    logic [bpss_pkg::TGT_W-1:0]   tgt_reg;
    logic [bpss_pkg::NB_W-1:0]    nb_reg;
    logic [bpss_pkg::SUM_W-1:0]   penalty_reg;
    logic [bpss_pkg::ACC_W-1:0]   acc_reg;
    logic [bpss_pkg::TILE_W-1:0]  best_idx_reg;
    logic [bpss_pkg::SCORE_W-1:0] best_reg;
    logic                         found_reg;

    logic                         lib_wr_ok;
    logic                         tgt_wr_ok;
    logic [bpss_pkg::LIB_AW-1:0]  lib_wr_addr;
    logic [bpss_pkg::LIB_AW-1:0]  lib_rd_addr;
    logic [bpss_pkg::TGT_AW-1:0]  tgt_wr_addr;
    logic [bpss_pkg::TGT_AW-1:0]  tgt_rd_addr;
    logic [bpss_pkg::TGT_W-1:0]   tgt_sel;
    logic [bpss_pkg::NB_W-1:0]    nb_next;
    logic                         nb_present;
    logic [bpss_pkg::PIX_W-1:0]   diff;
    logic [bpss_pkg::SUM_W-1:0]   sum;
    logic [bpss_pkg::SUM_W-1:0]   score;

    assign lib_wr_ok = cmd.lib_wr
                       && (32'(library_index) < 32'(bpss_pkg::LIBRARY_DEPTH))
                       && (32'(byte_position) < 32'(2 * bpss_pkg::PATCH_BYTES));
    assign tgt_wr_ok = cmd.tgt_wr
                       && (32'(target_index) < 32'(bpss_pkg::TARGET_DEPTH))
                       && (32'(byte_position) < 32'(bpss_pkg::PATCH_BYTES));

    assign lib_wr_addr = bpss_pkg::LIB_AW'(library_index)
                         * bpss_pkg::LIB_AW'(2 * bpss_pkg::PATCH_BYTES)
                         + bpss_pkg::LIB_AW'(byte_position);
    assign lib_rd_addr = bpss_pkg::LIB_AW'(cmd.tile)
                         * bpss_pkg::LIB_AW'(2 * bpss_pkg::PATCH_BYTES)
                         + (cmd.second_half ? bpss_pkg::LIB_AW'(bpss_pkg::PATCH_BYTES)
                                            : bpss_pkg::LIB_AW'(0))
                         + bpss_pkg::LIB_AW'(cmd.byte_idx);
    assign tgt_sel     = cmd.second_half ? nb_reg[bpss_pkg::TGT_W-1:0] : tgt_reg;
    assign tgt_wr_addr = bpss_pkg::TGT_AW'(target_index)
                         * bpss_pkg::TGT_AW'(bpss_pkg::PATCH_BYTES)
                         + bpss_pkg::TGT_AW'(byte_position);
    assign tgt_rd_addr = bpss_pkg::TGT_AW'(tgt_sel)
                         * bpss_pkg::TGT_AW'(bpss_pkg::PATCH_BYTES)
                         + bpss_pkg::TGT_AW'(cmd.byte_idx);

    always_ff @(posedge clk)
    begin
        if (lib_wr_ok)
        begin
            lib_mem[lib_wr_addr] <= pixel_value;
        end
        if (cmd.pix_rd)
        begin
            lib_q_reg <= lib_mem[lib_rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (tgt_wr_ok)
        begin
            tgt_mem[tgt_wr_addr] <= pixel_value;
        end
        if (cmd.pix_rd)
        begin
            tgt_q_reg <= tgt_mem[tgt_rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (lib_wr_ok)
        begin
            shape_mem[library_index[bpss_pkg::SHAPE_AW-1:0]] <= tile_shape;
        end
        if (cmd.shape_rd)
        begin
            shape_q_reg <= shape_mem[cmd.tile[bpss_pkg::SHAPE_AW-1:0]];
        end
    end

    assign nb_next = bpss_pkg::NB_W'(tgt_reg)
                     + ((shape_q_reg == bpss_pkg::SHAPE_LANDSCAPE)
                        ? bpss_pkg::NB_W'(column_height) : bpss_pkg::NB_W'(1));
    assign nb_present = (nb_next < bpss_pkg::NB_W'(target_count))
                        && (nb_next < bpss_pkg::NB_W'(bpss_pkg::TARGET_DEPTH));

    assign status.shape        = shape_q_reg;
    assign status.nb_present   = nb_present;
    assign status.tgt_in_range = (32'(target_index) < 32'(bpss_pkg::TARGET_DEPTH));

    assign diff  = (lib_q_reg > tgt_q_reg) ? (lib_q_reg - tgt_q_reg) : (tgt_q_reg - lib_q_reg);
    assign sum   = bpss_pkg::SUM_W'(acc_reg) + penalty_reg;
    assign score = (shape_q_reg == bpss_pkg::SHAPE_SQUARE) ? sum : (sum >> 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= cmd.pix_rd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.search_init)
        begin
            tgt_reg      <= target_index;
            best_reg     <= bpss_pkg::SCORE_LIMIT;
            best_idx_reg <= '0;
            found_reg    <= 1'b0;
        end
        else if (cmd.score_en && (score < bpss_pkg::SUM_W'(best_reg)))
        begin
            best_reg     <= score[bpss_pkg::SCORE_W-1:0];
            best_idx_reg <= cmd.tile;
            found_reg    <= 1'b1;
        end
        if (cmd.tile_setup)
        begin
            nb_reg  <= nb_next;
            acc_reg <= '0;
            if (shape_q_reg == bpss_pkg::SHAPE_SQUARE || nb_present)
            begin
                penalty_reg <= '0;
            end
            else if (shape_q_reg == bpss_pkg::SHAPE_LANDSCAPE)
            begin
                penalty_reg <= bpss_pkg::LANDSCAPE_PENALTY;
            end
            else
            begin
                penalty_reg <= bpss_pkg::PORTRAIT_PENALTY;
            end
        end
        else if (valid_reg)
        begin
            acc_reg <= acc_reg + bpss_pkg::ACC_W'(diff);
        end
    end

    assign best_entry  = found_reg ? best_idx_reg : '0;
    assign min_score   = found_reg ? best_reg : '0;
    assign match_found = found_reg;

endmodule

// ===== rtl/best_patch_sad_search_unit.sv =====
// ----------------------------------------------------------------------------
// best_patch_sad_search_unit
// Library/target patch store with a best-match search by sum of absolute
// differences, configured over an APB-style register port.
//
//   channel   signals                                   transfer at
//   request   start, busy, req_type .. tile_shape       start & !busy
//   result    done, best_entry, min_score, match_found  done high, one cycle
//   config    psel, penable, pwrite, paddr, pwdata      psel & penable & pwrite
//
// Loads are written as they are taken; busy stays low. A search reads one
// byte per cycle through the patch memory port: one cell for a square tile
// or a two-cell tile with missing neighbour, two cells for a two-cell tile
// with neighbour, and none for an unused shape. Reset clears the sequencer
// and config registers; patch memories and search registers are undefined
// until written. Results are shown for one cycle and cannot be stalled.
// ----------------------------------------------------------------------------
module best_patch_sad_search_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [bpss_pkg::REQ_W-1:0]    req_type,
    input  logic [bpss_pkg::TILE_W-1:0]   library_index,
    input  logic [bpss_pkg::TGT_W-1:0]    target_index,
    input  logic [bpss_pkg::POS_W-1:0]    byte_position,
    input  logic [bpss_pkg::PIX_W-1:0]    pixel_value,
    input  logic [bpss_pkg::SHAPE_W-1:0]  tile_shape,
    output logic                          done,
    output logic [bpss_pkg::TILE_W-1:0]   best_entry,
    output logic [bpss_pkg::SCORE_W-1:0]  min_score,
    output logic                          match_found,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bpss_pkg::CFG_AW-1:0]   paddr,
    input  logic [bpss_pkg::CFG_DW-1:0]   pwdata,
    output logic [bpss_pkg::CFG_DW-1:0]   prdata,
    output logic                          pready
);

    logic [bpss_pkg::LCOUNT_W-1:0] library_count_reg;
    logic [bpss_pkg::TCOUNT_W-1:0] target_count_reg;
    logic [bpss_pkg::TCOUNT_W-1:0] column_height_reg;
    logic                          cfg_wr;
    bpss_pkg::dp_cmd_t             cmd;
    bpss_pkg::dp_status_t          status;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            library_count_reg <= '0;
            target_count_reg  <= '0;
            column_height_reg <= bpss_pkg::TCOUNT_W'(1);
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                bpss_pkg::REG_LIBRARY_COUNT:
                begin
                    library_count_reg <= pwdata[bpss_pkg::LCOUNT_W-1:0];
                end
                bpss_pkg::REG_TARGET_COUNT:
                begin
                    target_count_reg <= pwdata[bpss_pkg::TCOUNT_W-1:0];
                end
                bpss_pkg::REG_COLUMN_HEIGHT:
                begin
                    column_height_reg <= pwdata[bpss_pkg::TCOUNT_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            bpss_pkg::REG_LIBRARY_COUNT: prdata = bpss_pkg::CFG_DW'(library_count_reg);
            bpss_pkg::REG_TARGET_COUNT:  prdata = bpss_pkg::CFG_DW'(target_count_reg);
            bpss_pkg::REG_COLUMN_HEIGHT: prdata = bpss_pkg::CFG_DW'(column_height_reg);
            default:                     prdata = '0;
        endcase
    end

    bpss_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .req_type      (req_type),
        .library_count (library_count_reg),
        .status        (status),
        .cmd           (cmd),
        .busy          (busy),
        .done          (done)
    );

    bpss_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .library_index (library_index),
        .target_index  (target_index),
        .byte_position (byte_position),
        .pixel_value   (pixel_value),
        .tile_shape    (tile_shape),
        .target_count  (target_count_reg),
        .column_height (column_height_reg),
        .best_entry    (best_entry),
        .min_score     (min_score),
        .match_found   (match_found)
    );

endmodule

// ===== test/best_patch_sad_search_unit_tb.sv =====
// ----------------------------------------------------------------------------
// best_patch_sad_search_unit_tb
// Self-checking bench for the best patch SAD search unit. Fills a pool of
// library tiles and target patches, backs every other library slot with an
// unused-shape tile, then runs directed and random searches under a range of
// register settings. A local model predicts each search result, and the
// results are compared field by field in order of arrival.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module best_patch_sad_search_unit_tb;

    localparam logic [bpss_pkg::REQ_W-1:0]   REQ_IGNORED  = 2'd3;
    localparam logic [bpss_pkg::SHAPE_W-1:0] SHAPE_UNUSED = 2'd3;
    localparam int POOL_TILES    = 12;
    localparam int SETTLE_CYCLES = 8;

    typedef struct packed {
        logic [bpss_pkg::REQ_W-1:0]   kind;
        logic [bpss_pkg::TILE_W-1:0]  tile;
        logic [bpss_pkg::TGT_W-1:0]   tgt;
        logic [bpss_pkg::POS_W-1:0]   pos;
        logic [bpss_pkg::PIX_W-1:0]   pix;
        logic [bpss_pkg::SHAPE_W-1:0] shape;
    } request_t;

    typedef struct packed {
        logic [bpss_pkg::TILE_W-1:0]  entry;
        logic [bpss_pkg::SCORE_W-1:0] score;
        logic                         found;
    } match_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           start = 1'b0;
    logic                           busy;
    logic [bpss_pkg::REQ_W-1:0]     req_type = '0;
    logic [bpss_pkg::TILE_W-1:0]    library_index = '0;
    logic [bpss_pkg::TGT_W-1:0]     target_index = '0;
    logic [bpss_pkg::POS_W-1:0]     byte_position = '0;
    logic [bpss_pkg::PIX_W-1:0]     pixel_value = '0;
    logic [bpss_pkg::SHAPE_W-1:0]   tile_shape = '0;
    logic                           done;
    logic [bpss_pkg::TILE_W-1:0]    best_entry;
    logic [bpss_pkg::SCORE_W-1:0]   min_score;
    logic                           match_found;
    logic                           psel = 1'b0;
    logic                           penable = 1'b0;
    logic                           pwrite = 1'b0;
    logic [bpss_pkg::CFG_AW-1:0]    paddr = '0;
    logic [bpss_pkg::CFG_DW-1:0]    pwdata = '0;
    logic [bpss_pkg::CFG_DW-1:0]    prdata;
    logic                           pready;

    best_patch_sad_search_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .req_type      (req_type),
        .library_index (library_index),
        .target_index  (target_index),
        .byte_position (byte_position),
        .pixel_value   (pixel_value),
        .tile_shape    (tile_shape),
        .done          (done),
        .best_entry    (best_entry),
        .min_score     (min_score),
        .match_found   (match_found),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    bit [bpss_pkg::PIX_W-1:0]   lib_pix_m [bpss_pkg::LIB_WORDS];
    bit [bpss_pkg::PIX_W-1:0]   tgt_pix_m [bpss_pkg::TGT_WORDS];
    bit [bpss_pkg::SHAPE_W-1:0] tile_shape_m [bpss_pkg::LIBRARY_DEPTH];
    logic [bpss_pkg::LCOUNT_W-1:0] lib_count_cfg = '0;
    logic [bpss_pkg::TCOUNT_W-1:0] tgt_count_cfg = '0;
    logic [bpss_pkg::TCOUNT_W-1:0] col_height_cfg = 1;

    bit                         tgt_full [bpss_pkg::TARGET_DEPTH];
    bit [bpss_pkg::PIX_W-1:0]   base_pat [8][bpss_pkg::PATCH_BYTES];

    request_t request_queue [$];
    match_t   expected_matches [$];

    int unsigned errors = 0;
    int unsigned results_checked = 0;
    int unsigned loads_sent = 0;
    int unsigned settings_used = 0;
    int          gap_left = 0;
    int          burst_left = 0;
    logic        presenting;

    function automatic logic [bpss_pkg::SUM_W-1:0] cell_sad(int tile, int half, int tgt);
        logic [bpss_pkg::SUM_W-1:0] s;
        logic [bpss_pkg::PIX_W-1:0] a;
        logic [bpss_pkg::PIX_W-1:0] b;
        s = '0;
        for (int k = 0; k < bpss_pkg::PATCH_BYTES; k++)
        begin
            a = lib_pix_m[(tile * 2 + half) * bpss_pkg::PATCH_BYTES + k];
            b = tgt_pix_m[tgt * bpss_pkg::PATCH_BYTES + k];
            s += (a > b) ? (a - b) : (b - a);
        end
        return s;
    endfunction

    function automatic match_t predict_best(logic [bpss_pkg::TGT_W-1:0] tgt);
        match_t                       r;
        logic [bpss_pkg::SUM_W-1:0]   score;
        logic [bpss_pkg::SUM_W-1:0]   best;
        logic [bpss_pkg::NB_W-1:0]    nb;
        logic [bpss_pkg::SHAPE_W-1:0] sh;
        int                           n;
        r = '0;
        best = bpss_pkg::SCORE_LIMIT;
        n = (lib_count_cfg > bpss_pkg::LIBRARY_DEPTH) ? bpss_pkg::LIBRARY_DEPTH
                                                      : int'(lib_count_cfg);
        for (int i = 0; i < n; i++)
        begin
            sh = tile_shape_m[i];
            if (sh == SHAPE_UNUSED)
                continue;
            score = cell_sad(i, 0, int'(tgt));
            if (sh != bpss_pkg::SHAPE_SQUARE)
            begin
                nb = bpss_pkg::NB_W'(tgt)
                     + ((sh == bpss_pkg::SHAPE_LANDSCAPE) ? bpss_pkg::NB_W'(col_height_cfg)
                                                          : bpss_pkg::NB_W'(1));
                if (nb < tgt_count_cfg && nb < bpss_pkg::TARGET_DEPTH)
                    score += cell_sad(i, 1, int'(nb));
                else if (sh == bpss_pkg::SHAPE_LANDSCAPE)
                    score += bpss_pkg::LANDSCAPE_PENALTY;
                else
                    score += bpss_pkg::PORTRAIT_PENALTY;
                score = score >> 1;
            end
            if (score < best)
            begin
                best = score;
                r.entry = bpss_pkg::TILE_W'(i);
                r.score = score[bpss_pkg::SCORE_W-1:0];
                r.found = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic void apply_request(request_t q);
        case (q.kind)
            bpss_pkg::REQ_LIB_LOAD:
            begin
                loads_sent++;
                if (q.pos < 2 * bpss_pkg::PATCH_BYTES)
                begin
                    lib_pix_m[int'(q.tile) * 2 * bpss_pkg::PATCH_BYTES + int'(q.pos)] = q.pix;
                    tile_shape_m[q.tile] = q.shape;
                end
            end
            bpss_pkg::REQ_TGT_LOAD:
            begin
                loads_sent++;
                if (q.pos < bpss_pkg::PATCH_BYTES)
                    tgt_pix_m[int'(q.tgt) * bpss_pkg::PATCH_BYTES + int'(q.pos)] = q.pix;
            end
            bpss_pkg::REQ_SEARCH:
                expected_matches = {expected_matches, predict_best(q.tgt)};
            default:
                ;
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            gap_left = 0;
            burst_left = 0;
        end
        else
        begin
            presenting = start;
            if (start && !busy)
            begin
                apply_request(request_queue.pop_front());
                presenting = 1'b0;
            end
            if (!presenting)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    start <= 1'b0;
                end
                else if (request_queue.size() > 0)
                begin
                    req_type      <= request_queue[0].kind;
                    library_index <= request_queue[0].tile;
                    target_index  <= request_queue[0].tgt;
                    byte_position <= request_queue[0].pos;
                    pixel_value   <= request_queue[0].pix;
                    tile_shape    <= request_queue[0].shape;
                    start         <= 1'b1;
                    if (burst_left > 1)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
                else
                    start <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        match_t want;
        if (rst_n && done)
        begin
            if (expected_matches.size() == 0)
            begin
                $display({"%0t: unexpected result, expected none, ",
                          "actual entry %0d score %0d found %0d"},
                         $time, best_entry, min_score, match_found);
                errors++;
            end
            else
            begin
                want = expected_matches.pop_front();
                results_checked++;
                if (best_entry !== want.entry)
                begin
                    $display("%0t: best_entry expected %0d, actual %0d",
                             $time, want.entry, best_entry);
                    errors++;
                end
                if (min_score !== want.score)
                begin
                    $display("%0t: min_score expected %0d, actual %0d",
                             $time, want.score, min_score);
                    errors++;
                end
                if (match_found !== want.found)
                begin
                    $display("%0t: match_found expected %0d, actual %0d",
                             $time, want.found, match_found);
                    errors++;
                end
            end
        end
    end

    task automatic push_request(logic [bpss_pkg::REQ_W-1:0] kind, int tile, int tgt, int pos,
                                int pix, logic [bpss_pkg::SHAPE_W-1:0] shape);
        request_t q;
        q.kind  = kind;
        q.tile  = bpss_pkg::TILE_W'(tile);
        q.tgt   = bpss_pkg::TGT_W'(tgt);
        q.pos   = bpss_pkg::POS_W'(pos);
        q.pix   = bpss_pkg::PIX_W'(pix);
        q.shape = shape;
        request_queue = {request_queue, q};
    endtask

    function automatic int jitter(bit [bpss_pkg::PIX_W-1:0] v, int amount);
        int t;
        t = int'(v) + int'($urandom_range(0, 2 * amount)) - amount;
        if (t < 0)
            t = 0;
        if (t > 255)
            t = 255;
        return t;
    endfunction

    function automatic int random_pixel();
        int sel;
        sel = $urandom_range(0, 3);
        if (sel == 0)
            return 0;
        if (sel == 1)
            return 255;
        return $urandom_range(0, 255);
    endfunction

    task automatic load_tile(int t, logic [bpss_pkg::SHAPE_W-1:0] shape, int base_a,
                             int base_b, int noise);
        int b;
        for (int k = 0; k < 2 * bpss_pkg::PATCH_BYTES; k++)
        begin
            b = (k < bpss_pkg::PATCH_BYTES) ? base_a : base_b;
            push_request(bpss_pkg::REQ_LIB_LOAD, t, 0, k,
                         jitter(base_pat[b][k % bpss_pkg::PATCH_BYTES], noise), shape);
        end
    endtask

    task automatic load_target(int t, int base, int noise);
        for (int k = 0; k < bpss_pkg::PATCH_BYTES; k++)
            push_request(bpss_pkg::REQ_TGT_LOAD, 0, t, k, jitter(base_pat[base][k], noise),
                         bpss_pkg::SHAPE_SQUARE);
        tgt_full[t] = 1'b1;
    endtask

    function automatic bit search_defined(int tgt);
        int nb;
        if (!tgt_full[tgt])
            return 1'b0;
        nb = tgt + 1;
        if (nb < tgt_count_cfg && nb < bpss_pkg::TARGET_DEPTH && !tgt_full[nb])
            return 1'b0;
        nb = tgt + int'(col_height_cfg);
        if (nb < tgt_count_cfg && nb < bpss_pkg::TARGET_DEPTH && !tgt_full[nb])
            return 1'b0;
        return 1'b1;
    endfunction

    task automatic queue_search(int tgt);
        if (search_defined(tgt))
            push_request(bpss_pkg::REQ_SEARCH, $urandom_range(0, bpss_pkg::LIBRARY_DEPTH - 1),
                         tgt, $urandom_range(0, 511), $urandom_range(0, 255),
                         bpss_pkg::SHAPE_W'($urandom_range(0, 3)));
    endtask

    task automatic wait_idle();
        while (request_queue.size() != 0 || start || busy || expected_matches.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(logic [1:0] idx, int value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= bpss_pkg::CFG_DW'(value);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            bpss_pkg::REG_LIBRARY_COUNT: lib_count_cfg = bpss_pkg::LCOUNT_W'(value);
            bpss_pkg::REG_TARGET_COUNT:  tgt_count_cfg = bpss_pkg::TCOUNT_W'(value);
            bpss_pkg::REG_COLUMN_HEIGHT: col_height_cfg = bpss_pkg::TCOUNT_W'(value);
            default: ;
        endcase
    endtask

    task automatic apb_read_check(logic [1:0] idx);
        logic [bpss_pkg::CFG_DW-1:0] want;
        logic [bpss_pkg::CFG_DW-1:0] mask;
        case (idx)
            bpss_pkg::REG_LIBRARY_COUNT:
            begin
                want = bpss_pkg::CFG_DW'(lib_count_cfg);
                mask = (1 << bpss_pkg::LCOUNT_W) - 1;
            end
            bpss_pkg::REG_TARGET_COUNT:
            begin
                want = bpss_pkg::CFG_DW'(tgt_count_cfg);
                mask = (1 << bpss_pkg::TCOUNT_W) - 1;
            end
            default:
            begin
                want = bpss_pkg::CFG_DW'(col_height_cfg);
                mask = (1 << bpss_pkg::TCOUNT_W) - 1;
            end
        endcase
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if ((prdata & mask) !== want)
        begin
            $display("%0t: register %0d readback expected %0d, actual %0d",
                     $time, idx, want, prdata & mask);
            errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_config(int lib_count, int tgt_count, int col_height);
        wait_idle();
        apb_write(bpss_pkg::REG_LIBRARY_COUNT, lib_count);
        apb_read_check(bpss_pkg::REG_LIBRARY_COUNT);
        apb_write(bpss_pkg::REG_TARGET_COUNT, tgt_count);
        apb_read_check(bpss_pkg::REG_TARGET_COUNT);
        apb_write(bpss_pkg::REG_COLUMN_HEIGHT, col_height);
        apb_read_check(bpss_pkg::REG_COLUMN_HEIGHT);
        settings_used++;
    endtask

    initial
    begin : stimulus
        int random_items;
        int r;
        int tgt;
        int picks;
        int lc;
        int tc;
        int ch;
        random_items = 0;
        for (int b = 0; b < 8; b++)
            for (int k = 0; k < bpss_pkg::PATCH_BYTES; k++)
                base_pat[b][k] = (b == 0) ? 8'd0 : (b == 1) ? 8'd255 : $urandom_range(0, 255);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        apb_read_check(bpss_pkg::REG_LIBRARY_COUNT);
        apb_read_check(bpss_pkg::REG_TARGET_COUNT);
        apb_read_check(bpss_pkg::REG_COLUMN_HEIGHT);

        for (int t = 0; t < 24; t++)
            load_target(t, t % 8, (t < 3) ? 0 : 3);
        for (int t = bpss_pkg::TARGET_DEPTH - 16; t < bpss_pkg::TARGET_DEPTH; t++)
            load_target(t, t % 8, 6);
        load_tile(0, bpss_pkg::SHAPE_SQUARE, 0, 0, 0);
        load_tile(1, bpss_pkg::SHAPE_SQUARE, 1, 1, 0);
        load_tile(2, bpss_pkg::SHAPE_SQUARE, 2, 2, 0);
        load_tile(3, bpss_pkg::SHAPE_SQUARE, 2, 2, 0);
        load_tile(4, bpss_pkg::SHAPE_LANDSCAPE, 3, 4, 4);
        load_tile(5, bpss_pkg::SHAPE_PORTRAIT, 4, 5, 4);
        load_tile(6, bpss_pkg::SHAPE_LANDSCAPE, 5, 6, 10);
        load_tile(7, bpss_pkg::SHAPE_PORTRAIT, 6, 7, 10);
        load_tile(8, SHAPE_UNUSED, 7, 7, 0);
        load_tile(9, bpss_pkg::SHAPE_SQUARE, 3, 3, 20);
        load_tile(10, bpss_pkg::SHAPE_LANDSCAPE, 2, 3, 2);
        load_tile(11, bpss_pkg::SHAPE_PORTRAIT, 3, 4, 2);
        for (int t = POOL_TILES; t < bpss_pkg::LIBRARY_DEPTH; t++)
            push_request(bpss_pkg::REQ_LIB_LOAD, t, 0,
                         $urandom_range(0, 2 * bpss_pkg::PATCH_BYTES - 1),
                         $urandom_range(0, 255), SHAPE_UNUSED);

        set_config(1, 0, 1);
        push_request(bpss_pkg::REQ_LIB_LOAD, 0, 0, 0, 0, bpss_pkg::SHAPE_PORTRAIT);
        queue_search(0);
        push_request(bpss_pkg::REQ_LIB_LOAD, 0, 0, 0, 0, SHAPE_UNUSED);
        queue_search(0);
        push_request(bpss_pkg::REQ_LIB_LOAD, 0, 0, 0, 0, bpss_pkg::SHAPE_SQUARE);
        queue_search(0);
        push_request(bpss_pkg::REQ_LIB_LOAD, 5, 0, 2 * bpss_pkg::PATCH_BYTES, 255,
                     bpss_pkg::SHAPE_SQUARE);
        push_request(bpss_pkg::REQ_LIB_LOAD, 4, 0, 511, 0, bpss_pkg::SHAPE_PORTRAIT);
        push_request(bpss_pkg::REQ_TGT_LOAD, 0, 3, bpss_pkg::PATCH_BYTES, 255,
                     bpss_pkg::SHAPE_SQUARE);
        push_request(bpss_pkg::REQ_TGT_LOAD, 0, 4, 511, 0, bpss_pkg::SHAPE_SQUARE);
        push_request(REQ_IGNORED, 2, 2, 0, 255, bpss_pkg::SHAPE_SQUARE);

        set_config(0, 0, 1);
        queue_search(0);
        set_config(POOL_TILES, 0, 1);
        queue_search(0);
        queue_search(1);
        queue_search(2);
        queue_search(3);
        queue_search(5);
        set_config(POOL_TILES, bpss_pkg::TARGET_DEPTH, 1);
        queue_search(3);
        queue_search(4);
        queue_search(22);
        set_config(POOL_TILES, 24, 8);
        queue_search(3);
        queue_search(15);
        queue_search(20);
        set_config(bpss_pkg::LIBRARY_DEPTH, bpss_pkg::TARGET_DEPTH, bpss_pkg::TARGET_DEPTH);
        queue_search(bpss_pkg::TARGET_DEPTH - 1);
        queue_search(bpss_pkg::TARGET_DEPTH - 16);
        queue_search(0);
        set_config(POOL_TILES, bpss_pkg::TARGET_DEPTH, bpss_pkg::TARGET_DEPTH - 16);
        queue_search(0);
        queue_search(15);

        while (random_items < 100)
        begin
            case ($urandom_range(0, 9))
                0:       lc = 0;
                1, 2, 3, 4, 5: lc = $urandom_range(1, POOL_TILES);
                6:       lc = bpss_pkg::LIBRARY_DEPTH;
                default: lc = $urandom_range(POOL_TILES + 1, bpss_pkg::LIBRARY_DEPTH - 1);
            endcase
            case ($urandom_range(0, 4))
                0:       tc = 0;
                1:       tc = bpss_pkg::TARGET_DEPTH;
                2:       tc = 24;
                3:       tc = $urandom_range(0, bpss_pkg::TARGET_DEPTH);
                default: tc = $urandom_range(2, 30);
            endcase
            case ($urandom_range(0, 4))
                0:       ch = 1;
                1:       ch = bpss_pkg::TARGET_DEPTH;
                2:       ch = $urandom_range(1, 23);
                3:       ch = $urandom_range(bpss_pkg::TARGET_DEPTH - 32,
                                             bpss_pkg::TARGET_DEPTH - 1);
                default: ch = $urandom_range(1, bpss_pkg::TARGET_DEPTH);
            endcase
            set_config(lc, tc, ch);
            repeat ($urandom_range(10, 16))
            begin
                r = $urandom_range(0, 99);
                if (r < 45)
                begin
                    picks = 0;
                    do
                    begin
                        tgt = ($urandom_range(0, 9) < 6)
                              ? $urandom_range(0, 23)
                              : $urandom_range(bpss_pkg::TARGET_DEPTH - 16,
                                               bpss_pkg::TARGET_DEPTH - 1);
                        picks++;
                    end
                    while (!search_defined(tgt) && picks < 30);
                    if (search_defined(tgt))
                    begin
                        queue_search(tgt);
                        random_items++;
                    end
                end
                else if (r < 70)
                begin
                    push_request(bpss_pkg::REQ_LIB_LOAD, $urandom_range(0, POOL_TILES - 1), 0,
                                 $urandom_range(0, 2 * bpss_pkg::PATCH_BYTES - 1),
                                 random_pixel(), bpss_pkg::SHAPE_W'($urandom_range(0, 3)));
                    random_items++;
                end
                else if (r < 85)
                begin
                    tgt = ($urandom_range(0, 1) == 0)
                          ? $urandom_range(0, 23)
                          : $urandom_range(bpss_pkg::TARGET_DEPTH - 16,
                                           bpss_pkg::TARGET_DEPTH - 1);
                    push_request(bpss_pkg::REQ_TGT_LOAD, 0, tgt,
                                 $urandom_range(0, bpss_pkg::PATCH_BYTES - 1),
                                 random_pixel(), bpss_pkg::SHAPE_SQUARE);
                    random_items++;
                end
                else
                begin
                    case ($urandom_range(0, 2))
                        0: push_request(REQ_IGNORED,
                                        $urandom_range(0, bpss_pkg::LIBRARY_DEPTH - 1),
                                        $urandom_range(0, bpss_pkg::TARGET_DEPTH - 1),
                                        $urandom_range(0, 511), $urandom_range(0, 255),
                                        bpss_pkg::SHAPE_W'($urandom_range(0, 3)));
                        1: push_request(bpss_pkg::REQ_LIB_LOAD,
                                        $urandom_range(0, POOL_TILES - 1), 0,
                                        $urandom_range(2 * bpss_pkg::PATCH_BYTES, 511),
                                        $urandom_range(0, 255),
                                        bpss_pkg::SHAPE_W'($urandom_range(0, 3)));
                        default: push_request(bpss_pkg::REQ_TGT_LOAD, 0,
                                              $urandom_range(0, bpss_pkg::TARGET_DEPTH - 1),
                                              $urandom_range(bpss_pkg::PATCH_BYTES, 511),
                                              $urandom_range(0, 255),
                                              bpss_pkg::SHAPE_SQUARE);
                    endcase
                end
            end
        end

        wait_idle();
        $display("Run covered %0d search results and %0d load transfers",
                 results_checked, loads_sent);
        $display("over %0d register settings.", settings_used);
        if (errors == 0)
            $display("best_patch_sad_search_unit_tb passed");
        else
            $display("best_patch_sad_search_unit_tb failed");
        $finish;
    end

    initial
    begin
        #(64'd50_000_000);
        $display("%0t: run timed out", $time);
        $display("best_patch_sad_search_unit_tb failed");
        $finish;
    end

endmodule
